// ===== design/voxel_ray_traversal_top_assert.svh =====
// Assertion macros for the voxel ray traversal block.
// Used by files that check their own control logic; expects clk and rst in scope.
`ifndef VOXEL_RAY_TRAVERSAL_TOP_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define VRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/vrt_pkg.sv =====
// Shared types and constants for the voxel ray traversal block.
// No dependencies.
package vrt_pkg;

  localparam int TIME_W = 32;
  localparam logic [TIME_W-1:0] TIME_INF = '1;

  localparam int MAXD_W = 16;
  localparam logic [MAXD_W-1:0] MAXD_RESET = 16'd1024;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_MAX_DISTANCE = 1'b0;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_END,
    ST_DIV_BND,
    ST_DIV_TPC,
    ST_EMIT,
    ST_STEP
  } state_t;

  typedef enum logic [1:0] {
    SGN_ZERO,
    SGN_POS,
    SGN_NEG
  } sgn_t;

endpackage

// ===== design/vrt_channels.sv =====
// Handshake channels of the voxel ray traversal block: request and response.
// No dependencies.
interface vrt_in_if #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16
);
  localparam int OW   = COORD_BITS + FRAC_BITS;
  localparam int DIRW = FRAC_BITS + 2;

  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic signed [OW-1:0]   origin_x;
  logic signed [OW-1:0]   origin_y;
  logic signed [OW-1:0]   origin_z;
  logic signed [DIRW-1:0] dir_x;
  logic signed [DIRW-1:0] dir_y;
  logic signed [DIRW-1:0] dir_z;

  modport source (output valid, cmd, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, cmd, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface vrt_out_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] cell_x;
  logic signed [COORD_BITS-1:0] cell_y;
  logic signed [COORD_BITS-1:0] cell_z;
  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  logic signed [COORD_BITS-1:0] prev_z;
  logic                         at_end;

  modport source (output valid, cell_x, cell_y, cell_z, prev_x, prev_y, prev_z, at_end,
                  input ready);
  modport sink   (input valid, cell_x, cell_y, cell_z, prev_x, prev_y, prev_z, at_end,
                  output ready);
endinterface

// ===== design/vrt_cfg.sv =====
// APB register file for the voxel ray traversal block (max_distance only).
// Depends on vrt_pkg.
module vrt_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vrt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [vrt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [vrt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [vrt_pkg::MAXD_W-1:0]     max_distance
);
  import vrt_pkg::*;

  logic reg_idx;
  logic wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance <= MAXD_RESET;
    end else if (wr_en && (reg_idx == REG_MAX_DISTANCE)) begin
      max_distance <= pwdata[MAXD_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAX_DISTANCE: prdata = {{(CFG_DATA_W-MAXD_W){1'b0}}, max_distance};
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== design/vrt_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle, shared by all setup divisions.
// Depends on nothing; caller never starts it with a zero divisor.
module vrt_div #(
  parameter int DVW  = 33,
  parameter int MAGW = 18
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DVW-1:0]  dividend,
  input  logic [MAGW-1:0] divisor,
  output logic            done,
  output logic [DVW-1:0]  quotient
);
  localparam int CW = $clog2(DVW + 1);

  logic [DVW-1:0]  dvd;
  logic [MAGW-1:0] dsr;
  logic [MAGW-1:0] rem;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [MAGW:0]   trial;
  logic [MAGW:0]   diff;
  logic            ge;

  assign trial    = {rem, dvd[DVW-1]};
  assign ge       = trial >= {1'b0, dsr};
  assign diff     = trial - {1'b0, dsr};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[MAGW-1:0] : trial[MAGW-1:0];
      dvd <= {dvd[DVW-2:0], ge};
    end
  end

endmodule

// ===== design/voxel_ray_traversal_top.sv =====
// Voxel ray traversal (3D DDA walk). Depends on vrt_pkg, vrt_channels, vrt_cfg, vrt_div.
// A step result is registered in ST_STEP after acceptance, once the output register is free.
// A start result is set by six divisions on the one shared radix-2 divider (a zero
// direction skips its two).
// One item is in work at a time; a finished result waits in the output register.
// Reset (rst, synchronous): cells zero, times all ones, max_distance 1024.
`include "voxel_ray_traversal_top_assert.svh"

module voxel_ray_traversal_top #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  vrt_in_if.sink                         req,
  vrt_out_if.source                      rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vrt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [vrt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [vrt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import vrt_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int OW   = C + F;          // origin width
  localparam int DIRW = F + 2;          // direction width
  localparam int PW   = DIRW + MAXD_W + 1; // dir * max_distance
  localparam int RW   = PW + 1;         // frac + product
  localparam int NUMW = F + 1;          // boundary distance, up to one cell
  localparam int DVW  = 2 * F + 1;      // dividend, up to 2^(2F)
  localparam int MAGW = DIRW;           // |dir|
  localparam int QX   = (DVW > TIME_W) ? DVW : TIME_W + 1;

  state_t state, state_next;

  // configuration
  logic [MAXD_W-1:0] maxd;

  // latched start payload
  logic [2:0][OW-1:0]   org;
  logic [2:0][DIRW-1:0] dirr;

  // traversal state
  logic [2:0][C-1:0]      cur;
  logic [2:0][C-1:0]      prev;
  logic [2:0][C-1:0]      endc;
  logic [2:0][TIME_W-1:0] nbt;   // next boundary time
  logic [2:0][TIME_W-1:0] tpc;   // time per cell
  sgn_t                   sgn [0:2];
  logic [1:0]             ax;    // axis under setup

  // per-axis setup working registers
  logic signed [PW-1:0] prod;
  logic [F-1:0]         frac;
  logic [MAGW-1:0]      mag;
  logic [NUMW-1:0]      num;

  // output register
  logic         rsp_valid;
  logic [C-1:0] o_cx, o_cy, o_cz, o_px, o_py, o_pz;
  logic         o_end;

  // FSM outputs
  logic rdy;
  logic div_start;
  logic step_go;
  logic emit_go;
  logic out_free;

  // divider
  logic [DVW-1:0] div_dvd;
  logic           div_done;
  logic [DVW-1:0] div_q;

  vrt_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .max_distance (maxd)
  );

  vrt_div #(.DVW(DVW), .MAGW(MAGW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (mag),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------------------------------------------------------------------
  // Setup datapath: selected axis operands
  // ---------------------------------------------------------------------------
  logic [OW-1:0]   org_sel;
  logic [DIRW-1:0] dir_sel;
  logic            dir_neg;
  logic            dir_zero;
  logic            mag_zero;

  assign org_sel  = org[ax];
  assign dir_sel  = dirr[ax];
  assign dir_neg  = dir_sel[DIRW-1];
  assign dir_zero = (dir_sel == '0);
  assign mag_zero = (mag == '0);

  // end cell = floor(origin) + floor((frac + dir*max_distance) / 2^F)
  logic signed [RW-1:0] reach;
  logic signed [RW-1:0] reach_sh;
  logic [C+RW-1:0]      end_sum;

  assign reach    = $signed({{(RW-F){1'b0}}, frac}) + $signed({prod[PW-1], prod});
  assign reach_sh = reach >>> F;
  assign end_sum  = {{RW{cur[ax][C-1]}}, cur[ax]} + {{C{reach_sh[RW-1]}}, reach_sh};

  // first division: boundary distance << F; second: one cell << F, i.e. 2^(2F)
  assign div_dvd = (state == ST_DIV_BND) ? {1'b1, {(2*F){1'b0}}} : {num, {F{1'b0}}};

  // quotient saturates to all ones when it overflows the time width
  logic [QX-1:0]     q_ext;
  logic [TIME_W-1:0] time_sat;

  assign q_ext    = QX'(div_q);
  assign time_sat = (|q_ext[QX-1:TIME_W]) ? TIME_INF : q_ext[TIME_W-1:0];

  // ---------------------------------------------------------------------------
  // Step datapath: pick the axis with the smallest boundary time, ties to the
  // later axis; a step at the end cell changes nothing.
  // ---------------------------------------------------------------------------
  logic [1:0]             sel;
  logic                   same;
  logic [TIME_W:0]        nbt_sum;
  logic [2:0][C-1:0]      cur_step;
  logic [2:0][C-1:0]      prev_step;
  logic [2:0][TIME_W-1:0] nbt_step;

  always_comb begin
    cur_step  = cur;
    prev_step = prev;
    nbt_step  = nbt;
    same      = (cur == endc);
    if (nbt[AXIS_X] < nbt[AXIS_Y] && nbt[AXIS_X] < nbt[AXIS_Z]) begin
      sel = AXIS_X;
    end else if (nbt[AXIS_Y] < nbt[AXIS_Z]) begin
      sel = AXIS_Y;
    end else begin
      sel = AXIS_Z;
    end
    nbt_sum = {1'b0, nbt[sel]} + {1'b0, tpc[sel]};
    if (!same) begin
      prev_step = cur;
      case (sgn[sel])
        SGN_POS: cur_step[sel] = cur[sel] + {{(C-1){1'b0}}, 1'b1};
        SGN_NEG: cur_step[sel] = cur[sel] - {{(C-1){1'b0}}, 1'b1};
        default: cur_step[sel] = cur[sel];
      endcase
      nbt_step[sel] = nbt_sum[TIME_W] ? TIME_INF : nbt_sum[TIME_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign out_free = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = (req.cmd == CMD_STEP) ? ST_STEP : ST_MUL;
        end
      end
      ST_MUL: state_next = ST_END;
      ST_END: begin
        if (!mag_zero) begin
          state_next = ST_DIV_BND;
        end else begin
          state_next = (ax == AXIS_Z) ? ST_EMIT : ST_MUL;
        end
      end
      ST_DIV_BND: begin
        if (div_done) begin
          state_next = ST_DIV_TPC;
        end
      end
      ST_DIV_TPC: begin
        if (div_done) begin
          state_next = (ax == AXIS_Z) ? ST_EMIT : ST_MUL;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_STEP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rdy       = 1'b0;
    div_start = 1'b0;
    step_go   = 1'b0;
    emit_go   = 1'b0;
    unique case (state)
      ST_IDLE:    rdy = 1'b1;
      ST_END:     div_start = !mag_zero;
      ST_DIV_BND: div_start = div_done;
      ST_EMIT:    emit_go = out_free;
      ST_STEP:    step_go = out_free;
      default: begin
        rdy = 1'b0;
      end
    endcase
  end

  assign req.ready = rdy;

  // ---------------------------------------------------------------------------
  // Architectural state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cur  <= '0;
      prev <= '0;
      endc <= '0;
      nbt  <= '1;
      tpc  <= '1;
      sgn  <= '{SGN_ZERO, SGN_ZERO, SGN_ZERO};
      ax   <= AXIS_X;
    end else begin
      unique case (state)
        ST_IDLE: begin
          ax <= AXIS_X;
        end
        ST_MUL: begin
          cur[ax]  <= org_sel[OW-1:F];
          prev[ax] <= org_sel[OW-1:F];
          sgn[ax]  <= dir_zero ? SGN_ZERO : (dir_neg ? SGN_NEG : SGN_POS);
        end
        ST_END: begin
          endc[ax] <= end_sum[C-1:0];
          if (mag_zero) begin
            nbt[ax] <= TIME_INF;
            tpc[ax] <= TIME_INF;
            if (ax != AXIS_Z) begin
              ax <= ax + 2'd1;
            end
          end
        end
        ST_DIV_BND: begin
          if (div_done) begin
            nbt[ax] <= time_sat;
          end
        end
        ST_DIV_TPC: begin
          if (div_done) begin
            tpc[ax] <= time_sat;
            if (ax != AXIS_Z) begin
              ax <= ax + 2'd1;
            end
          end
        end
        ST_STEP: begin
          if (step_go) begin
            cur  <= cur_step;
            prev <= prev_step;
            nbt  <= nbt_step;
          end
        end
        default: begin
          ax <= AXIS_X;
        end
      endcase
    end
  end

  // result beat: loaded on emit or step, dropped once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (step_go || emit_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers (no reset)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (req.valid && rdy) begin
      org[AXIS_X]  <= req.origin_x;
      org[AXIS_Y]  <= req.origin_y;
      org[AXIS_Z]  <= req.origin_z;
      dirr[AXIS_X] <= req.dir_x;
      dirr[AXIS_Y] <= req.dir_y;
      dirr[AXIS_Z] <= req.dir_z;
    end
    if (state == ST_MUL) begin
      prod <= $signed(dir_sel) * $signed({1'b0, maxd});
      frac <= org_sel[F-1:0];
      mag  <= dir_neg ? MAGW'(-dir_sel) : dir_sel;
      num  <= dir_neg ? {1'b0, org_sel[F-1:0]}
                      : ({1'b1, {F{1'b0}}} - {1'b0, org_sel[F-1:0]});
    end
    if (step_go) begin
      o_cx  <= cur_step[AXIS_X];
      o_cy  <= cur_step[AXIS_Y];
      o_cz  <= cur_step[AXIS_Z];
      o_px  <= prev_step[AXIS_X];
      o_py  <= prev_step[AXIS_Y];
      o_pz  <= prev_step[AXIS_Z];
      o_end <= (cur_step == endc);
    end else if (emit_go) begin
      o_cx  <= cur[AXIS_X];
      o_cy  <= cur[AXIS_Y];
      o_cz  <= cur[AXIS_Z];
      o_px  <= prev[AXIS_X];
      o_py  <= prev[AXIS_Y];
      o_pz  <= prev[AXIS_Z];
      o_end <= (cur == endc);
    end
  end

  assign rsp.valid  = rsp_valid;
  assign rsp.cell_x = o_cx;
  assign rsp.cell_y = o_cy;
  assign rsp.cell_z = o_cz;
  assign rsp.prev_x = o_px;
  assign rsp.prev_y = o_py;
  assign rsp.prev_z = o_pz;
  assign rsp.at_end = o_end;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `VRT_ASSERT_NXT(a_accept_busy, req.valid && req.ready, state != ST_IDLE, "accepted beat left the sequencer idle")
  `VRT_ASSERT_NXT(a_end_holds, step_go && same, $stable(cur) && $stable(nbt), "step at end cell moved the walk")
  `VRT_ASSERT_NXT(a_time_grows, step_go, nbt[0] >= $past(nbt[0]) && nbt[1] >= $past(nbt[1]) && nbt[2] >= $past(nbt[2]), "boundary time went backward")
  `VRT_ASSERT_IMP(a_rsp_source, $rose(rsp_valid), $past(state == ST_STEP) || $past(state == ST_EMIT), "result raised outside emit or step")

endmodule
